// ===== design/hts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, character codes and entity tables for the HTML text
// extractor.
// ----------------------------------------------------------------------------
package hts_pkg;

    // widths and sizes
    localparam int COUNT_BITS_DEF = 16;
    localparam int CHAR_W         = 8;
    localparam int LIMIT_W        = 16;
    localparam int LEN_W          = 16;
    localparam int ENT_COUNT      = 5;
    localparam int HOLD_MAX       = 6;
    localparam int QUEUE_DEPTH    = HOLD_MAX - 1;
    localparam int HCNT_W         = 3;

    typedef logic [CHAR_W-1:0] t_char;

    // character codes
    localparam t_char CH_AMP   = 8'h26;
    localparam t_char CH_LT    = 8'h3C;
    localparam t_char CH_GT    = 8'h3E;
    localparam t_char CH_QUOT  = 8'h22;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_HASH  = 8'h23;
    localparam t_char CH_SEMI  = 8'h3B;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_CR    = 8'h0D;

    // named entities: text, length and decoded byte
    localparam t_char ENT_TEXT [ENT_COUNT][HOLD_MAX] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // &amp;
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // &gt;
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // &quot;
        '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}    // &nbsp;
    };
    localparam logic [HCNT_W-1:0] ENT_LEN [ENT_COUNT] = '{
        3'd5, 3'd4, 3'd4, 3'd6, 3'd6
    };
    localparam t_char ENT_VALUE [ENT_COUNT] = '{
        CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_SPACE
    };

    // one input beat as held in the input register
    typedef struct packed {
        logic  valid;
        t_char ch;
        logic  doc_end;
    } t_item;

    // one parser step as seen by the output stage
    typedef struct packed {
        logic             go;
        logic             emit;
        t_char            ch;
        logic [LEN_W-1:0] len;
        logic             done;
    } t_step;

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input t_char c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== design/hts_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_in_reg
// Input register: captures one beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module hts_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  hts_pkg::t_char  i_in_char,
    input  logic            i_doc_end,
    input  logic            i_take,
    output hts_pkg::t_item  o_item
);

    logic           r_valid;
    hts_pkg::t_char r_ch;
    logic           r_doc_end;
    logic           accept;

    // stall only while a held beat is not being taken
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch      <= i_in_char;
            r_doc_end <= i_doc_end;
        end
    end

    assign o_item = '{valid: r_valid, ch: r_ch, doc_end: r_doc_end};

endmodule

// ===== design/hts_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_engine
// Parser: one byte or one flush action per cycle unless the output stage
// holds it. Tracks markup, numeric entity skipping, whitespace collapse,
// named entity matching, output limit, and replay of a failed partial entity.
// ----------------------------------------------------------------------------
module hts_engine #(
    parameter int COUNT_BITS = hts_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hts_pkg::t_item               i_item,
    output logic                         o_take,
    input  logic                         i_step_ok,
    input  logic [hts_pkg::LIMIT_W-1:0]  i_limit,
    output hts_pkg::t_step               o_step
);

    localparam int QD  = hts_pkg::QUEUE_DEPTH;
    localparam int HW  = hts_pkg::HCNT_W;
    localparam int ENC = hts_pkg::ENT_COUNT;

    // parser state
    logic                  r_markup, n_markup;
    logic                  r_prev, n_prev;
    logic                  r_skip, n_skip;
    logic [HW-1:0]         r_hcnt, n_hcnt;
    logic [ENC-1:0]        r_cand, n_cand;
    hts_pkg::t_char        r_held [QD];
    hts_pkg::t_char        n_held [QD];
    hts_pkg::t_char        r_rq [QD];
    hts_pkg::t_char        n_rq [QD];
    logic [HW-1:0]         r_rqcnt, n_rqcnt;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_act, r_end;

    logic                  go, src_q, flush, cur_end, done;
    hts_pkg::t_char        b, wbyte, fval;
    logic                  want, emit, count_ok, full, pref;
    logic [ENC-1:0]        still;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [31:0]           cnt_inc32;

    // step control
    assign go      = (r_act || i_item.valid) && i_step_ok;
    assign o_take  = go && !r_act;
    assign src_q   = r_act && (r_rqcnt != '0);
    assign flush   = r_act && (r_rqcnt == '0);
    assign b       = src_q ? r_rq[0] : i_item.ch;
    assign cur_end = r_act ? r_end : i_item.doc_end;

    // entity candidates after this byte
    always_comb begin
        still = '0;
        full  = 1'b0;
        pref  = 1'b0;
        fval  = hts_pkg::CH_AMP;
        for (int k = 0; k < ENC; k++) begin
            still[k] = r_cand[k] && (r_hcnt < hts_pkg::ENT_LEN[k])
                       && (hts_pkg::ENT_TEXT[k][r_hcnt] == b);
            if (still[k] && ((r_hcnt + 3'd1) == hts_pkg::ENT_LEN[k])) begin
                if (!full) begin
                    fval = hts_pkg::ENT_VALUE[k];
                end
                full = 1'b1;
            end else if (still[k]) begin
                pref = 1'b1;
            end
        end
    end

    // byte processing
    always_comb begin
        n_markup = r_markup;
        n_prev   = r_prev;
        n_skip   = r_skip;
        n_hcnt   = r_hcnt;
        n_cand   = r_cand;
        n_held   = r_held;
        n_rq     = r_rq;
        n_rqcnt  = r_rqcnt;
        want     = 1'b0;
        wbyte    = b;

        // pop the replay queue head
        if (src_q) begin
            for (int i = 0; i < QD - 1; i++) begin
                n_rq[i] = r_rq[i + 1];
            end
            n_rqcnt = r_rqcnt - 3'd1;
        end

        if (flush) begin
            // document end with a partial entity: emit '&' and replay the rest
            if (r_hcnt != '0) begin
                want    = 1'b1;
                wbyte   = hts_pkg::CH_AMP;
                n_prev  = 1'b0;
                n_rq    = r_held;
                n_rqcnt = r_hcnt - 3'd1;
                n_hcnt  = '0;
            end
        end else if (r_hcnt != '0) begin
            if ((r_hcnt == 3'd1) && (b == hts_pkg::CH_HASH)) begin
                n_skip = 1'b1;
                n_hcnt = '0;
            end else if (full) begin
                want   = 1'b1;
                wbyte  = fval;
                n_hcnt = '0;
            end else if (pref) begin
                n_hcnt                = r_hcnt + 3'd1;
                n_cand                = still;
                n_held[r_hcnt - 3'd1] = b;
            end else begin
                // no entity matches: '&', then the held bytes again
                want   = 1'b1;
                wbyte  = hts_pkg::CH_AMP;
                n_prev = 1'b0;
                for (int i = 0; i < QD; i++) begin
                    n_rq[i] = (HW'(i) == (r_hcnt - 3'd1)) ? b : r_held[i];
                end
                n_rqcnt = r_hcnt;
                n_hcnt  = '0;
            end
        end else if (r_skip) begin
            if (b == hts_pkg::CH_SEMI) begin
                n_skip = 1'b0;
            end
        end else if (b == hts_pkg::CH_LT) begin
            n_markup = 1'b1;
        end else if (b == hts_pkg::CH_GT) begin
            n_markup = 1'b0;
        end else if (r_markup) begin
            n_markup = 1'b1;
        end else if (b == hts_pkg::CH_AMP) begin
            n_hcnt = 3'd1;
            n_cand = '1;
        end else if (hts_pkg::is_space(b)) begin
            if (!r_prev) begin
                want   = 1'b1;
                wbyte  = hts_pkg::CH_SPACE;
                n_prev = 1'b1;
            end
        end else begin
            want   = 1'b1;
            n_prev = 1'b0;
        end
    end

    // output limit and counter saturation
    assign count_ok  = (32'(r_count) < 32'(i_limit)) && (r_count != {COUNT_BITS{1'b1}});
    assign emit      = go && want && count_ok;
    assign cnt_inc   = r_count + COUNT_BITS'(1);
    assign cnt_inc32 = 32'(cnt_inc);
    assign n_count   = emit ? cnt_inc : r_count;
    assign done      = (n_rqcnt == '0) && !(cur_end && (n_hcnt != '0));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_markup <= 1'b0;
            r_prev   <= 1'b1;
            r_skip   <= 1'b0;
            r_hcnt   <= '0;
            r_rqcnt  <= '0;
            r_count  <= '0;
            r_act    <= 1'b0;
            r_end    <= 1'b0;
        end else if (go) begin
            r_act   <= !done;
            r_rqcnt <= n_rqcnt;
            if (o_take) begin
                r_end <= i_item.doc_end;
            end
            if (done && cur_end) begin
                r_markup <= 1'b0;
                r_prev   <= 1'b1;
                r_skip   <= 1'b0;
                r_hcnt   <= '0;
                r_count  <= '0;
            end else begin
                r_markup <= n_markup;
                r_prev   <= n_prev;
                r_skip   <= n_skip;
                r_hcnt   <= n_hcnt;
                r_count  <= n_count;
            end
        end
    end

    // held bytes, candidates and replay queue
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_cand <= n_cand;
            r_held <= n_held;
            r_rq   <= n_rq;
        end
    end

    assign o_step = '{go: go, emit: emit, ch: wbyte,
                      len: cnt_inc32[hts_pkg::LEN_W-1:0], done: go && done};

endmodule

// ===== design/hts_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_out
// Output stage: a pending slot that waits until it is known whether a result
// is the last one of its input beat, then the output register.
// ----------------------------------------------------------------------------
module hts_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hts_pkg::t_step             i_step,
    output logic                       o_step_ok,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output hts_pkg::t_char             o_out_char,
    output logic                       o_run_last,
    output logic [hts_pkg::LEN_W-1:0]  o_text_length
);

    logic                      r_pend_v, r_pend_fin;
    hts_pkg::t_char            r_pend_ch;
    logic [hts_pkg::LEN_W-1:0] r_pend_len;
    logic                      r_out_v, r_out_last;
    hts_pkg::t_char            r_out_ch;
    logic [hts_pkg::LEN_W-1:0] r_out_len;
    logic                      out_free, pend_move;

    assign out_free  = !r_out_v || !i_out_stall;
    assign o_step_ok = out_free || !r_pend_v;
    // pending result leaves once it is final or a newer one replaces it
    assign pend_move = r_pend_v && out_free && (r_pend_fin || i_step.emit);

    // pending slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v   <= 1'b0;
            r_pend_fin <= 1'b0;
        end else if (i_step.emit) begin
            r_pend_v   <= 1'b1;
            r_pend_fin <= i_step.done;
        end else if (pend_move) begin
            r_pend_v   <= 1'b0;
            r_pend_fin <= 1'b0;
        end else if (i_step.go && i_step.done && r_pend_v) begin
            r_pend_fin <= 1'b1;
        end
    end

    // pending slot payload
    always_ff @(posedge i_clk) begin
        if (i_step.emit) begin
            r_pend_ch  <= i_step.ch;
            r_pend_len <= i_step.len;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (pend_move) begin
            r_out_v <= 1'b1;
        end else if (out_free) begin
            r_out_v <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_ch   <= r_pend_ch;
            r_out_len  <= r_pend_len;
            r_out_last <= r_pend_fin;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_out_char    = r_out_ch;
    assign o_run_last    = r_out_last;
    assign o_text_length = r_out_len;

endmodule

// ===== design/html_tag_strip_text_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_tag_strip_text_top
// Streaming HTML to plain text extractor: drops markup, decodes named
// entities, skips numeric entities and collapses whitespace.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one HTML byte per beat (i_in_char) with i_doc_end on the
//   final byte of a document. Output channel: one text byte per beat with a
//   running length and o_run_last on the last beat caused by an input beat.
//   Both channels use valid/stall; a beat moves when valid is high and stall
//   is low.
//   Path: the last result of an input beat moves from the pending slot into
//   the output register; earlier results of a burst wait for the next result.
//   Throughput: one input beat per cycle while no extra steps are needed and
//   the receiver does not stall. The parser does one step a cycle when the
//   output stage allows it: a failed partial entity adds a step per byte
//   after its '&', a flush at document end adds steps for the '&' and the
//   held bytes, and the input stalls during the extra steps.
//   i_cfg_wr_en writes the output limit (reset 65535); write it only while
//   idle. Reset clears all channel state and starts a new document.
//   A receiver stall holds the output beat and, once the pending slot is
//   full, stops the parser and then the input.
// ----------------------------------------------------------------------------
module html_tag_strip_text_top #(
    parameter int COUNT_BITS = hts_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_in_char,
    input  logic                         i_doc_end,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_out_char,
    output logic                         o_run_last,
    output logic [15:0]                  o_text_length,
    input  logic                         i_cfg_wr_en,
    input  logic [hts_pkg::LIMIT_W-1:0]  i_cfg_wr_data
);

    logic [hts_pkg::LIMIT_W-1:0] r_output_limit;
    hts_pkg::t_item              item;
    hts_pkg::t_step              step;
    logic                        take, step_ok;

    // output limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit <= {hts_pkg::LIMIT_W{1'b1}};
        end else if (i_cfg_wr_en) begin
            r_output_limit <= i_cfg_wr_data;
        end
    end

    hts_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_char  (i_in_char),
        .i_doc_end  (i_doc_end),
        .i_take     (take),
        .o_item     (item)
    );

    hts_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .o_take    (take),
        .i_step_ok (step_ok),
        .i_limit   (r_output_limit),
        .o_step    (step)
    );

    hts_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .o_step_ok     (step_ok),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_text_length (o_text_length)
    );

endmodule

// ===== design/hts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_checker
// Port level checks for the HTML text extractor, bound to the top level.
// ----------------------------------------------------------------------------
module hts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_char,
    input logic        o_run_last,
    input logic [15:0] o_text_length
);

    // stalled output beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // stalled output payload does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_out_char) && $stable(o_run_last) && $stable(o_text_length))
        else $error("output payload changed while stalled");

    // reset leaves both channels quiet
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channel active right after reset");

    // inside one burst the running length steps by one
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_last ##1 o_out_valid |->
            o_text_length == 16'($past(o_text_length) + 16'd1))
        else $error("text length skipped inside a burst");

endmodule

bind html_tag_strip_text_top hts_checker u_hts_checker (.*);

// ===== verif/html_tag_strip_text_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_tag_strip_text_check
// Watches the byte and text channels of the extractor, keeps its own model
// of the markup, entity and whitespace state, and compares every text beat
// against the oldest predicted beat.
// ----------------------------------------------------------------------------
module html_tag_strip_text_check #(
    parameter int COUNT_BITS = hts_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_doc_end,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_char,
    input  logic        i_run_last,
    input  logic [15:0] i_text_length,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_beats_checked
);
    import hts_pkg::*;

    localparam int     MAX_BEATS = 7;
    localparam int     ENTITIES  = 5;
    localparam longint COUNT_CAP = (longint'(1) << COUNT_BITS) - 1;

    typedef struct packed {
        t_char       ch;
        logic        last;
        logic [15:0] len;
    } t_text_beat;

    // named entities and the byte each one decodes to
    string ent_name [ENTITIES] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&nbsp;"};
    t_char ent_byte [ENTITIES] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_SPACE};

    // extractor state
    logic [15:0] text_limit;
    logic        in_tag;
    logic        after_space;
    logic        in_numeric;
    t_char       held [HOLD_MAX];
    int          held_n;
    longint      emitted;

    t_char       replay [$];
    t_text_beat  burst [$];
    t_text_beat  expected_text [$];
    int          fails = 0;
    int          checked = 0;

    function automatic void restart_document();
        in_tag      = 1'b0;
        after_space = 1'b1;
        in_numeric  = 1'b0;
        held_n      = 0;
        emitted     = 0;
    endfunction

    // one text byte, dropped once the burst or the limit is full
    function automatic void emit_text(t_char c);
        t_text_beat b;
        if (burst.size() >= MAX_BEATS) return;
        if (emitted >= longint'(text_limit) || emitted >= COUNT_CAP) return;
        emitted++;
        b = '{c, 1'b0, 16'(emitted)};
        burst.push_back(b);
    endfunction

    function automatic void emit_literal(t_char c);
        emit_text(c);
        after_space = 1'b0;
    endfunction

    // failed partial entity: literal '&', bytes after it go back in front
    function automatic void abandon_entity();
        emit_literal(CH_AMP);
        for (int k = held_n - 1; k >= 1; k--) replay.push_front(held[k]);
        held_n = 0;
    endfunction

    // 2 on a full match, 1 on a strict prefix, 0 on no match
    function automatic int entity_match(output t_char value);
        int  found;
        bit  same;
        found = 0;
        value = '0;
        for (int e = 0; e < ENTITIES; e++) begin
            if (held_n > ent_name[e].len()) continue;
            same = 1'b1;
            for (int k = 0; k < held_n; k++) begin
                if (held[k] != t_char'(ent_name[e][k])) same = 1'b0;
            end
            if (!same) continue;
            if (held_n == ent_name[e].len()) begin
                value = ent_byte[e];
                return 2;
            end
            found = 1;
        end
        return found;
    endfunction

    function automatic void parse_byte(t_char c);
        t_char value;
        int    m;
        // entity being collected
        if (held_n > 0 && held_n < HOLD_MAX) begin
            held[held_n] = c;
            held_n++;
            if (held_n == 2 && held[1] == CH_HASH) begin
                in_numeric = 1'b1;
                held_n     = 0;
                return;
            end
            m = entity_match(value);
            if (m == 2) begin
                emit_text(value);
                held_n = 0;
            end else if (m == 0) begin
                abandon_entity();
            end
            return;
        end
        if (held_n >= HOLD_MAX) abandon_entity();
        // numeric entity swallows everything up to ';'
        if (in_numeric) begin
            if (c == CH_SEMI) in_numeric = 1'b0;
            return;
        end
        if (c == CH_LT) begin
            in_tag = 1'b1;
            return;
        end
        if (c == CH_GT) begin
            in_tag = 1'b0;
            return;
        end
        if (in_tag) return;
        if (c == CH_AMP) begin
            held[0] = c;
            held_n  = 1;
            return;
        end
        // whitespace run collapses to one space
        if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
            if (!after_space) begin
                emit_text(CH_SPACE);
                after_space = 1'b1;
            end
            return;
        end
        emit_literal(c);
    endfunction

    function automatic void drain_replay();
        while (replay.size() > 0) parse_byte(replay.pop_front());
    endfunction

    // text beats caused by one html byte
    function automatic void predict_text(t_char c, logic doc_last);
        t_text_beat b;
        burst.delete();
        replay.push_back(c);
        drain_replay();
        if (doc_last) begin
            while (held_n > 0) begin
                abandon_entity();
                drain_replay();
            end
            restart_document();
        end
        if (burst.size() > 0) begin
            b = burst.pop_back();
            b.last = 1'b1;
            burst.push_back(b);
        end
        foreach (burst[i]) expected_text.push_back(burst[i]);
    endfunction

    function automatic void check_text();
        t_text_beat want;
        checked++;
        if (expected_text.size() == 0) begin
            $error("text beat 0x%02h arrived with nothing expected", i_out_char);
            fails++;
            return;
        end
        want = expected_text.pop_front();
        if (i_out_char !== want.ch) begin
            $error("out_char: expected 0x%02h, got 0x%02h", want.ch, i_out_char);
            fails++;
        end
        if (i_run_last !== want.last) begin
            $error("run_last: expected %0d, got %0d", want.last, i_run_last);
            fails++;
        end
        if (i_text_length !== want.len) begin
            $error("text_length: expected %0d, got %0d", want.len, i_text_length);
            fails++;
        end
    endfunction

    // sample both channels and the limit writes at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_limit = 16'hFFFF;
            restart_document();
            replay.delete();
            expected_text.delete();
        end else begin
            if (i_cfg_wr_en) text_limit = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) predict_text(i_in_char, i_doc_end);
            if (i_out_valid && !i_out_stall) check_text();
        end
        o_pending       <= expected_text.size();
        o_fail_count    <= fails;
        o_beats_checked <= checked;
    end

endmodule

// ===== verif/html_tag_strip_text_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_tag_strip_text_top_test
// Drives html bytes into the extractor under several output limits, with
// random gaps and receiver stalls, one long receiver hold-off, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module html_tag_strip_text_top_test;
    import hts_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_OFF_CYCLES = 150;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_html_byte;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_char     = '0;
    logic        i_doc_end     = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_run_last;
    logic [15:0] o_text_length;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    t_html_byte  html_q [$];
    string       entity_text [5] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&nbsp;"};
    int          bytes_sent     = 0;
    int          documents      = 0;
    int          limit_settings = 0;
    int          idle_cycles    = 0;
    bit          no_gaps        = 1'b0;
    bit          hold_off_req   = 1'b0;
    int          fail_count;
    int          pending_text;
    int          beats_checked;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    html_tag_strip_text_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_char     (i_in_char),
        .i_doc_end     (i_doc_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_text_length (o_text_length),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    html_tag_strip_text_check text_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_char       (i_in_char),
        .i_doc_end       (i_doc_end),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_char      (o_out_char),
        .i_run_last      (o_run_last),
        .i_text_length   (o_text_length),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_text),
        .o_beats_checked (beats_checked)
    );

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("html_tag_strip_text_top regression: fail");
                $finish;
            end
        end
    end

    // receiver stalls, mostly short, now and then long, one forced hold-off
    initial begin
        int pick;
        int span;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    i_out_stall <= 1'b0;
                    span = $urandom_range(1, 16);
                end else if (pick < 85) begin
                    i_out_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end else if (pick < 97) begin
                    i_out_stall <= 1'b1;
                    span = $urandom_range(4, 12);
                end else begin
                    i_out_stall <= 1'b1;
                    span = $urandom_range(20, 40);
                end
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // one byte beat with an optional gap ahead of it
    task automatic send_byte(t_html_byte b);
        int pick;
        int gap;
        gap = 0;
        if (!no_gaps) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      gap = 0;
            else if (pick < 88) gap = $urandom_range(1, 3);
            else if (pick < 97) gap = $urandom_range(4, 10);
            else                gap = $urandom_range(15, 30);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= b.ch;
        i_doc_end  <= b.last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (b.last) documents++;
    endtask

    task automatic pump();
        while (html_q.size() > 0) send_byte(html_q.pop_front());
        i_in_valid <= 1'b0;
    endtask

    // wait for every predicted beat, then let a byte with no text finish
    task automatic settle();
        do @(posedge i_clk); while (pending_text != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_settings++;
    endtask

    task automatic add_text(string s);
        for (int k = 0; k < s.len(); k++) html_q.push_back('{t_char'(s[k]), 1'b0});
    endtask

    // one byte, now and then the last of its document
    task automatic add_byte(t_char c);
        html_q.push_back('{c, ($urandom_range(0, 29) == 0)});
    endtask

    // one html fragment: mostly well formed, some broken, some noise
    task automatic add_fragment();
        int kind;
        int n;
        int e;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) add_byte(t_char'(8'h41 + $urandom_range(0, 25)));
                else add_byte(t_char'(8'h61 + $urandom_range(0, 25)));
            end
        end else if (kind < 32) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0) add_byte(CH_SPACE);
                else add_byte(t_char'($urandom_range(9, 13)));
            end
        end else if (kind < 44) begin
            add_byte(CH_LT);
            n = $urandom_range(0, 4);
            repeat (n) add_byte(t_char'($urandom_range(32, 126)));
            add_byte(CH_GT);
        end else if (kind < 62) begin
            e = $urandom_range(0, 4);
            for (int k = 0; k < entity_text[e].len(); k++) add_byte(t_char'(entity_text[e][k]));
        end else if (kind < 72) begin
            // entity prefix that breaks off
            e = $urandom_range(0, 4);
            n = $urandom_range(1, entity_text[e].len() - 1);
            for (int k = 0; k < n; k++) add_byte(t_char'(entity_text[e][k]));
            if ($urandom_range(0, 2) == 0) add_byte(CH_AMP);
            else add_byte(t_char'($urandom_range(0, 255)));
        end else if (kind < 80) begin
            add_byte(CH_AMP);
            add_byte(CH_HASH);
            n = $urandom_range(0, 4);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0) add_byte(CH_LT);
                else add_byte(t_char'(8'h30 + $urandom_range(0, 9)));
            end
            add_byte(CH_SEMI);
        end else if (kind < 92) begin
            add_byte(t_char'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 3))
                0: add_byte(CH_GT);
                1: add_byte(CH_SEMI);
                2: add_byte(CH_HASH);
                default: add_byte(CH_AMP);
            endcase
        end
    endtask

    task automatic add_random(int count);
        int start;
        start = html_q.size();
        while (html_q.size() - start < count) add_fragment();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: leading and collapsed space, tag, decode, numeric skip
        // with a tag inside, stray '>', byte extremes, long failed entity,
        // partial entity flushed at document end
        write_limit(16'hFFFF);
        add_text(" H\t\n<b>&lt;&#<;>");
        html_q.push_back('{8'hFF, 1'b0});
        html_q.push_back('{8'h00, 1'b0});
        add_text("&nbspx&");
        html_q.push_back('{t_char'(8'h71), 1'b1});
        pump();
        settle();

        // nothing may come out at all
        write_limit(16'h0000);
        add_random(15);
        pump();
        settle();

        write_limit(16'h0001);
        add_random(20);
        pump();
        settle();

        // small limit under a long receiver hold-off, sender back to back
        write_limit(16'h0007);
        add_random(40);
        no_gaps = 1'b1;
        hold_off_req = 1'b1;
        wait (hold_off_req == 1'b0);
        pump();
        no_gaps = 1'b0;
        settle();

        write_limit(16'($urandom_range(2, 40)));
        add_random(40);
        pump();
        settle();

        write_limit(16'hFFFF);
        add_random(40);
        pump();
        settle();

        $display("sent %0d html bytes, %0d documents closed, %0d output limit settings",
                 bytes_sent, documents, limit_settings);
        $display("compared %0d text beats, %0d mismatches", beats_checked, fail_count);
        if (fail_count == 0)
            $display("html_tag_strip_text_top regression: pass");
        else
            $display("html_tag_strip_text_top regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/hts_pkg.sv
design/hts_in_reg.sv
design/hts_engine.sv
design/hts_out.sv
design/html_tag_strip_text_top.sv
design/hts_checker.sv
verif/html_tag_strip_text_check.sv
verif/html_tag_strip_text_top_test.sv
